### src/assert_macros.svh
// Assertion macros for concurrent checks, included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk, ignored while arst_n is low.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication checked on every rising edge of clk.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked on every rising edge of clk.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/rossler_pkg.sv
// Shared constants, command types and the saturation helper of the Rossler step block.
`timescale 1ns / 1ps

package rossler_pkg;

	// Sizes of the point store and the screen.
	localparam int NUM_POINTS    = 5;
	localparam int SCREEN_WIDTH  = 1920;
	localparam int SCREEN_HEIGHT = 1080;
	localparam int PT_AW         = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;

	// Number formats.
	localparam int FRAC_BITS = 21;
	localparam int COORD_W   = 32;
	localparam int PIX_W     = 12;
	localparam int OPND_W    = 33;
	localparam int PROD_W    = 2 * OPND_W;
	localparam int Q21_W     = PROD_W - FRAC_BITS;
	localparam int Q42_W     = PROD_W - 2 * FRAC_BITS;
	localparam int SAT_W     = 48;
	localparam int IDX_W     = 4;

	localparam logic [PROD_W-1:0] HALF_FRAC = PROD_W'(1) << (FRAC_BITS - 1);
	localparam logic [PROD_W-1:0] HALF_PIX  = PROD_W'(1) << (2 * FRAC_BITS - 1);

	// Configuration register indexes.
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_STEP_SIZE     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_COEF_A        = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_COEF_B        = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_COEF_C        = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_X_WINDOW_MIN  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_Y_WINDOW_MIN  = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_X_PIXEL_SCALE = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_Y_PIXEL_SCALE = 3'd7;

	// Configuration reset values.
	localparam logic [30:0]        STEP_SIZE_RST     = 31'd18874;
	localparam logic signed [31:0] COEF_A_RST        = 32'sd419430;
	localparam logic signed [31:0] COEF_B_RST        = 32'sd419430;
	localparam logic signed [31:0] COEF_C_RST        = 32'sd20971520;
	localparam logic signed [31:0] X_WINDOW_MIN_RST  = -32'sd41943040;
	localparam logic signed [31:0] Y_WINDOW_MIN_RST  = -32'sd62914560;
	localparam logic [30:0]        X_PIXEL_SCALE_RST = 31'd90596966;
	localparam logic [30:0]        Y_PIXEL_SCALE_RST = 31'd33973862;

	// Action codes of an input item.
	localparam logic ACT_ADVANCE = 1'b0;
	localparam logic ACT_LOAD    = 1'b1;

	// Operand pairs of the shared multiplier.
	localparam int MUL_SEL_W = 3;
	localparam logic [MUL_SEL_W-1:0] MUL_AY = 3'd0;
	localparam logic [MUL_SEL_W-1:0] MUL_DX = 3'd1;
	localparam logic [MUL_SEL_W-1:0] MUL_XZ = 3'd2;
	localparam logic [MUL_SEL_W-1:0] MUL_CZ = 3'd3;
	localparam logic [MUL_SEL_W-1:0] MUL_DY = 3'd4;
	localparam logic [MUL_SEL_W-1:0] MUL_DZ = 3'd5;
	localparam logic [MUL_SEL_W-1:0] MUL_PX = 3'd6;
	localparam logic [MUL_SEL_W-1:0] MUL_PY = 3'd7;

	// Destinations of a rounded product.
	localparam int WB_SEL_W = 4;
	localparam logic [WB_SEL_W-1:0] WB_NONE = 4'd0;
	localparam logic [WB_SEL_W-1:0] WB_AY   = 4'd1;
	localparam logic [WB_SEL_W-1:0] WB_DX   = 4'd2;
	localparam logic [WB_SEL_W-1:0] WB_XZ   = 4'd3;
	localparam logic [WB_SEL_W-1:0] WB_CZ   = 4'd4;
	localparam logic [WB_SEL_W-1:0] WB_DY   = 4'd5;
	localparam logic [WB_SEL_W-1:0] WB_DZ   = 4'd6;
	localparam logic [WB_SEL_W-1:0] WB_PX   = 4'd7;
	localparam logic [WB_SEL_W-1:0] WB_PY   = 4'd8;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic                 capture;
		logic [MUL_SEL_W-1:0] mul_sel;
		logic [WB_SEL_W-1:0]  wb_sel;
		logic                 neg_en;
		logic                 sdy_en;
		logic                 sdz_en;
		logic                 nx_en;
		logic                 ny_en;
		logic                 nz_en;
		logic                 pxd_en;
		logic                 pyd_en;
		logic                 emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic item_load;
		logic item_in_range;
	} sts_t;

	// Saturate a sign-extended value to the signed 32 bit range.
	function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
		logic signed [COORD_W-1:0] r;
		if (v[SAT_W-1:COORD_W-1] == '0 || v[SAT_W-1:COORD_W-1] == '1) begin
			r = v[COORD_W-1:0];
		end else if (v[SAT_W-1]) begin
			r = {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(COORD_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

### src/rossler_item_if.sv
// Input item channel: valid/ready handshake with the advance or load payload.
`timescale 1ns / 1ps

interface rossler_item_if;
	logic                                    valid;
	logic                                    ready;
	logic                                    action;
	logic [rossler_pkg::IDX_W-1:0]           point_index;
	logic signed [rossler_pkg::COORD_W-1:0]  load_x;
	logic signed [rossler_pkg::COORD_W-1:0]  load_y;
	logic signed [rossler_pkg::COORD_W-1:0]  load_z;

	modport source (output valid, action, point_index, load_x, load_y, load_z, input ready);
	modport sink (input valid, action, point_index, load_x, load_y, load_z, output ready);
endinterface

### src/rossler_result_if.sv
// Result channel: valid/ready handshake with the new coordinates and pixel indices.
`timescale 1ns / 1ps

interface rossler_result_if;
	logic                                    valid;
	logic                                    ready;
	logic [rossler_pkg::IDX_W-1:0]           out_index;
	logic signed [rossler_pkg::COORD_W-1:0]  pos_x;
	logic signed [rossler_pkg::COORD_W-1:0]  pos_y;
	logic signed [rossler_pkg::COORD_W-1:0]  pos_z;
	logic [rossler_pkg::PIX_W-1:0]           pixel_col;
	logic [rossler_pkg::PIX_W-1:0]           pixel_row;
	logic                                    on_screen;

	modport source (output valid, out_index, pos_x, pos_y, pos_z, pixel_col, pixel_row,
		on_screen, input ready);
	modport sink (input valid, out_index, pos_x, pos_y, pos_z, pixel_col, pixel_row,
		on_screen, output ready);
endinterface

### src/rossler_cfg_if.sv
// Configuration write channel: valid/ready handshake with register index and data.
`timescale 1ns / 1ps

interface rossler_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [rossler_pkg::REG_IDX_W-1:0]    index;
	logic [rossler_pkg::COORD_W-1:0]      data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### src/rossler_ctrl.sv
// Controller: sequences the shared multiplier schedule for one item at a time.
`timescale 1ns / 1ps

module rossler_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	output logic                res_valid,
	input  logic                res_ready,
	input  rossler_pkg::sts_t   sts,
	output rossler_pkg::cmd_t   cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	// Schedule positions: advance runs steps one to ten, load runs eleven to fourteen.
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] ADV_FIRST = 4'd1;
	localparam logic [STEP_W-1:0] ADV_LAST  = 4'd10;
	localparam logic [STEP_W-1:0] LD_FIRST  = 4'd11;
	localparam logic [STEP_W-1:0] LD_LAST   = 4'd14;

	logic [1:0]        state_q;
	logic [STEP_W-1:0] step_q;
	logic              res_valid_q;
	logic              accept;
	logic              emit;

	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid && item_ready;
	assign emit       = (state_q == ST_DONE) && (!res_valid_q || res_ready);
	assign res_valid  = res_valid_q;

	// Command decode for the current schedule step.
	always_comb begin
		cmd         = '0;
		cmd.capture = accept;
		cmd.emit    = emit;
		cmd.mul_sel = rossler_pkg::MUL_AY;
		cmd.wb_sel  = rossler_pkg::WB_NONE;
		if (state_q == ST_RUN) begin
			unique case (step_q)
				4'd1: begin
					cmd.mul_sel = rossler_pkg::MUL_AY;
					cmd.neg_en  = 1'b1;
				end
				4'd2: begin
					cmd.mul_sel = rossler_pkg::MUL_DX;
					cmd.wb_sel  = rossler_pkg::WB_AY;
				end
				4'd3: begin
					cmd.mul_sel = rossler_pkg::MUL_XZ;
					cmd.wb_sel  = rossler_pkg::WB_DX;
					cmd.sdy_en  = 1'b1;
				end
				4'd4: begin
					cmd.mul_sel = rossler_pkg::MUL_CZ;
					cmd.wb_sel  = rossler_pkg::WB_XZ;
					cmd.nx_en   = 1'b1;
				end
				4'd5: begin
					cmd.mul_sel = rossler_pkg::MUL_DY;
					cmd.wb_sel  = rossler_pkg::WB_CZ;
					cmd.pxd_en  = 1'b1;
				end
				4'd6: begin
					cmd.mul_sel = rossler_pkg::MUL_PX;
					cmd.wb_sel  = rossler_pkg::WB_DY;
					cmd.sdz_en  = 1'b1;
				end
				4'd7: begin
					cmd.mul_sel = rossler_pkg::MUL_DZ;
					cmd.wb_sel  = rossler_pkg::WB_PX;
					cmd.ny_en   = 1'b1;
				end
				4'd8: begin
					cmd.wb_sel  = rossler_pkg::WB_DZ;
					cmd.pyd_en  = 1'b1;
				end
				4'd9: begin
					cmd.mul_sel = rossler_pkg::MUL_PY;
					cmd.nz_en   = 1'b1;
				end
				4'd10: begin
					cmd.wb_sel  = rossler_pkg::WB_PY;
				end
				4'd11: begin
					cmd.pxd_en  = 1'b1;
					cmd.pyd_en  = 1'b1;
				end
				4'd12: begin
					cmd.mul_sel = rossler_pkg::MUL_PX;
				end
				4'd13: begin
					cmd.mul_sel = rossler_pkg::MUL_PY;
					cmd.wb_sel  = rossler_pkg::WB_PX;
				end
				4'd14: begin
					cmd.wb_sel  = rossler_pkg::WB_PY;
				end
				default: begin
				end
			endcase
		end
	end

	// State, step counter and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (!sts.item_in_range) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_RUN;
							step_q  <= (sts.item_load == rossler_pkg::ACT_LOAD) ?
								LD_FIRST : ADV_FIRST;
						end
					end
				end
				ST_RUN: begin
					if (step_q == ADV_LAST || step_q == LD_LAST) begin
						state_q <= ST_DONE;
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				ST_DONE: begin
					if (emit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### src/rossler_dp.sv
// Datapath: point store, configuration registers, shared multiplier and result register.
`timescale 1ns / 1ps

module rossler_dp (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  rossler_pkg::cmd_t                       cmd,
	output rossler_pkg::sts_t                       sts,
	input  logic                                    item_action,
	input  logic [rossler_pkg::IDX_W-1:0]           item_point_index,
	input  logic signed [rossler_pkg::COORD_W-1:0]  item_load_x,
	input  logic signed [rossler_pkg::COORD_W-1:0]  item_load_y,
	input  logic signed [rossler_pkg::COORD_W-1:0]  item_load_z,
	input  logic                                    cfg_we,
	input  logic [rossler_pkg::REG_IDX_W-1:0]       cfg_index,
	input  logic [rossler_pkg::COORD_W-1:0]         cfg_data,
	output logic [rossler_pkg::IDX_W-1:0]           out_index,
	output logic signed [rossler_pkg::COORD_W-1:0]  pos_x,
	output logic signed [rossler_pkg::COORD_W-1:0]  pos_y,
	output logic signed [rossler_pkg::COORD_W-1:0]  pos_z,
	output logic [rossler_pkg::PIX_W-1:0]           pixel_col,
	output logic [rossler_pkg::PIX_W-1:0]           pixel_row,
	output logic                                    on_screen
);

	localparam int CW = rossler_pkg::COORD_W;
	localparam int PW = rossler_pkg::PROD_W;
	localparam int OW = rossler_pkg::OPND_W;
	localparam int XW = rossler_pkg::PIX_W;
	localparam int AW = rossler_pkg::PT_AW;

	// Configuration registers.
	logic [30:0]          step_size_q;
	logic signed [CW-1:0] coef_a_q;
	logic signed [CW-1:0] coef_b_q;
	logic signed [CW-1:0] coef_c_q;
	logic signed [CW-1:0] x_window_min_q;
	logic signed [CW-1:0] y_window_min_q;
	logic [30:0]          x_pixel_scale_q;
	logic [30:0]          y_pixel_scale_q;

	// Point store.
	logic signed [CW-1:0] point_x_q [rossler_pkg::NUM_POINTS];
	logic signed [CW-1:0] point_y_q [rossler_pkg::NUM_POINTS];
	logic signed [CW-1:0] point_z_q [rossler_pkg::NUM_POINTS];

	// Per-item working registers.
	logic [rossler_pkg::IDX_W-1:0] idx_q;
	logic                          inr_q;
	logic signed [CW-1:0] ox_q, oy_q, oz_q;
	logic signed [CW-1:0] t_ay_q, t_xz_q, t_cz_q;
	logic signed [CW-1:0] d_x_q, d_y_q, d_z_q;
	logic signed [CW-1:0] s_dy_q, s_dz_q;
	logic signed [CW-1:0] nx_q, ny_q, nz_q;
	logic [OW-1:0]        neg_yz_q;
	logic [OW-1:0]        pxd_q, pyd_q;
	logic [XW-1:0]        col_q, row_q;
	logic                 ok_q;
	logic signed [PW-1:0] prod_q;

	// Result register.
	logic [rossler_pkg::IDX_W-1:0] out_index_q;
	logic signed [CW-1:0]          pos_x_q, pos_y_q, pos_z_q;
	logic [XW-1:0]                 pixel_col_q, pixel_row_q;
	logic                          on_screen_q;

	logic                 item_in_range;
	logic [AW-1:0]        rd_addr;
	logic [AW-1:0]        wr_addr;
	logic [OW-1:0]        opa, opb;
	logic [PW-1:0]        rsum_frac, rsum_pix;
	logic signed [rossler_pkg::Q21_W-1:0] q21;
	logic signed [rossler_pkg::Q42_W-1:0] q42;
	logic signed [CW-1:0] r21;
	logic [XW-1:0]        pix_x, pix_y;
	logic                 oob_x, oob_y;
	logic [CW:0]          sum_yz;
	logic signed [CW-1:0] sat_yz;
	logic [CW:0]          sum_dy;
	logic [CW+1:0]        sum_dz;
	logic [CW:0]          sum_nx, sum_ny, sum_nz;

	assign item_in_range = ({1'b0, item_point_index} < (rossler_pkg::IDX_W + 1)'(rossler_pkg::NUM_POINTS));
	assign sts.item_load     = item_action;
	assign sts.item_in_range = item_in_range;
	assign rd_addr = item_point_index[AW-1:0];
	assign wr_addr = idx_q[AW-1:0];

	// Multiplier operand selection.
	always_comb begin
		case (cmd.mul_sel)
			rossler_pkg::MUL_AY: begin
				opa = {coef_a_q[CW-1], coef_a_q};
				opb = {oy_q[CW-1], oy_q};
			end
			rossler_pkg::MUL_DX: begin
				opa = neg_yz_q;
				opb = {2'b00, step_size_q};
			end
			rossler_pkg::MUL_XZ: begin
				opa = {ox_q[CW-1], ox_q};
				opb = {oz_q[CW-1], oz_q};
			end
			rossler_pkg::MUL_CZ: begin
				opa = {coef_c_q[CW-1], coef_c_q};
				opb = {oz_q[CW-1], oz_q};
			end
			rossler_pkg::MUL_DY: begin
				opa = {s_dy_q[CW-1], s_dy_q};
				opb = {2'b00, step_size_q};
			end
			rossler_pkg::MUL_DZ: begin
				opa = {s_dz_q[CW-1], s_dz_q};
				opb = {2'b00, step_size_q};
			end
			rossler_pkg::MUL_PX: begin
				opa = pxd_q;
				opb = {2'b00, x_pixel_scale_q};
			end
			rossler_pkg::MUL_PY: begin
				opa = pyd_q;
				opb = {2'b00, y_pixel_scale_q};
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	// Round to nearest with ties away from zero, by 21 bits and by 42 bits.
	always_comb begin
		rsum_frac = $unsigned(prod_q) + rossler_pkg::HALF_FRAC - {{(PW-1){1'b0}}, prod_q[PW-1]};
		rsum_pix  = $unsigned(prod_q) + rossler_pkg::HALF_PIX - {{(PW-1){1'b0}}, prod_q[PW-1]};
		q21 = $signed(rsum_frac[PW-1:rossler_pkg::FRAC_BITS]);
		q42 = $signed(rsum_pix[PW-1:2*rossler_pkg::FRAC_BITS]);
		r21 = rossler_pkg::sat32(rossler_pkg::SAT_W'(q21));
	end

	// Clamp a pixel index to the screen and flag indices that fell outside.
	always_comb begin
		pix_x = q42[XW-1:0];
		oob_x = 1'b0;
		if (q42[rossler_pkg::Q42_W-1]) begin
			pix_x = '0;
			oob_x = 1'b1;
		end else if (q42[rossler_pkg::Q42_W-2:0] >=
				(rossler_pkg::Q42_W - 1)'(rossler_pkg::SCREEN_WIDTH)) begin
			pix_x = XW'(rossler_pkg::SCREEN_WIDTH - 1);
			oob_x = 1'b1;
		end
		pix_y = q42[XW-1:0];
		oob_y = 1'b0;
		if (q42[rossler_pkg::Q42_W-1]) begin
			pix_y = '0;
			oob_y = 1'b1;
		end else if (q42[rossler_pkg::Q42_W-2:0] >=
				(rossler_pkg::Q42_W - 1)'(rossler_pkg::SCREEN_HEIGHT)) begin
			pix_y = XW'(rossler_pkg::SCREEN_HEIGHT - 1);
			oob_y = 1'b1;
		end
	end

	// Exact sums ahead of saturation.
	always_comb begin
		sum_yz = {oy_q[CW-1], oy_q} + {oz_q[CW-1], oz_q};
		sat_yz = rossler_pkg::sat32(rossler_pkg::SAT_W'($signed(sum_yz)));
		sum_dy = {ox_q[CW-1], ox_q} + {t_ay_q[CW-1], t_ay_q};
		sum_dz = {{2{coef_b_q[CW-1]}}, coef_b_q} + {{2{t_xz_q[CW-1]}}, t_xz_q}
			- {{2{t_cz_q[CW-1]}}, t_cz_q};
		sum_nx = {ox_q[CW-1], ox_q} + {d_x_q[CW-1], d_x_q};
		sum_ny = {oy_q[CW-1], oy_q} + {d_y_q[CW-1], d_y_q};
		sum_nz = {oz_q[CW-1], oz_q} + {d_z_q[CW-1], d_z_q};
	end

	// Configuration registers: user writes only while the block is idle; unchecked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_size_q     <= rossler_pkg::STEP_SIZE_RST;
			coef_a_q        <= rossler_pkg::COEF_A_RST;
			coef_b_q        <= rossler_pkg::COEF_B_RST;
			coef_c_q        <= rossler_pkg::COEF_C_RST;
			x_window_min_q  <= rossler_pkg::X_WINDOW_MIN_RST;
			y_window_min_q  <= rossler_pkg::Y_WINDOW_MIN_RST;
			x_pixel_scale_q <= rossler_pkg::X_PIXEL_SCALE_RST;
			y_pixel_scale_q <= rossler_pkg::Y_PIXEL_SCALE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rossler_pkg::REG_STEP_SIZE:     step_size_q     <= cfg_data[30:0];
				rossler_pkg::REG_COEF_A:        coef_a_q        <= cfg_data;
				rossler_pkg::REG_COEF_B:        coef_b_q        <= cfg_data;
				rossler_pkg::REG_COEF_C:        coef_c_q        <= cfg_data;
				rossler_pkg::REG_X_WINDOW_MIN:  x_window_min_q  <= cfg_data;
				rossler_pkg::REG_Y_WINDOW_MIN:  y_window_min_q  <= cfg_data;
				rossler_pkg::REG_X_PIXEL_SCALE: x_pixel_scale_q <= cfg_data[30:0];
				rossler_pkg::REG_Y_PIXEL_SCALE: y_pixel_scale_q <= cfg_data[30:0];
				default: begin
				end
			endcase
		end
	end

	// Point store: cleared at reset, written when an in-range result is issued.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rossler_pkg::NUM_POINTS; i++) begin
				point_x_q[i] <= '0;
				point_y_q[i] <= '0;
				point_z_q[i] <= '0;
			end
		end else if (cmd.emit && inr_q) begin
			point_x_q[wr_addr] <= nx_q;
			point_y_q[wr_addr] <= ny_q;
			point_z_q[wr_addr] <= nz_q;
		end
	end

	// Shared multiplier with registered product.
	always_ff @(posedge clk) begin
		prod_q <= $signed(opa) * $signed(opb);
	end

	// Item capture, intermediate terms and pixel indices.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			idx_q <= item_point_index;
			inr_q <= item_in_range;
			ok_q  <= 1'b1;
			if (item_in_range) begin
				if (item_action == rossler_pkg::ACT_LOAD) begin
					nx_q <= item_load_x;
					ny_q <= item_load_y;
					nz_q <= item_load_z;
				end else begin
					ox_q <= point_x_q[rd_addr];
					oy_q <= point_y_q[rd_addr];
					oz_q <= point_z_q[rd_addr];
				end
			end
		end
		if (cmd.neg_en) begin
			neg_yz_q <= {OW{1'b0}} - {sat_yz[CW-1], sat_yz};
		end
		if (cmd.sdy_en) begin
			s_dy_q <= rossler_pkg::sat32(rossler_pkg::SAT_W'($signed(sum_dy)));
		end
		if (cmd.sdz_en) begin
			s_dz_q <= rossler_pkg::sat32(rossler_pkg::SAT_W'($signed(sum_dz)));
		end
		if (cmd.nx_en) begin
			nx_q <= rossler_pkg::sat32(rossler_pkg::SAT_W'($signed(sum_nx)));
		end
		if (cmd.ny_en) begin
			ny_q <= rossler_pkg::sat32(rossler_pkg::SAT_W'($signed(sum_ny)));
		end
		if (cmd.nz_en) begin
			nz_q <= rossler_pkg::sat32(rossler_pkg::SAT_W'($signed(sum_nz)));
		end
		if (cmd.pxd_en) begin
			pxd_q <= {nx_q[CW-1], nx_q} - {x_window_min_q[CW-1], x_window_min_q};
		end
		if (cmd.pyd_en) begin
			pyd_q <= {ny_q[CW-1], ny_q} - {y_window_min_q[CW-1], y_window_min_q};
		end
		case (cmd.wb_sel)
			rossler_pkg::WB_AY: t_ay_q <= r21;
			rossler_pkg::WB_DX: d_x_q  <= r21;
			rossler_pkg::WB_XZ: t_xz_q <= r21;
			rossler_pkg::WB_CZ: t_cz_q <= r21;
			rossler_pkg::WB_DY: d_y_q  <= r21;
			rossler_pkg::WB_DZ: d_z_q  <= r21;
			rossler_pkg::WB_PX: begin
				col_q <= pix_x;
				if (oob_x) begin
					ok_q <= 1'b0;
				end
			end
			rossler_pkg::WB_PY: begin
				row_q <= pix_y;
				if (oob_y) begin
					ok_q <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	// Result register, loaded when the controller issues the result.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_index_q <= idx_q;
			if (inr_q) begin
				pos_x_q     <= nx_q;
				pos_y_q     <= ny_q;
				pos_z_q     <= nz_q;
				pixel_col_q <= col_q;
				pixel_row_q <= row_q;
				on_screen_q <= ok_q;
			end else begin
				pos_x_q     <= '0;
				pos_y_q     <= '0;
				pos_z_q     <= '0;
				pixel_col_q <= '0;
				pixel_row_q <= '0;
				on_screen_q <= 1'b0;
			end
		end
	end

	assign out_index = out_index_q;
	assign pos_x     = pos_x_q;
	assign pos_y     = pos_y_q;
	assign pos_z     = pos_z_q;
	assign pixel_col = pixel_col_q;
	assign pixel_row = pixel_row_q;
	assign on_screen = on_screen_q;

endmodule

### src/rossler_euler_step_to_pixel.sv
// Rossler attractor Euler step with pixel mapping: top level.
// Usage:
// The item channel takes one transaction per item. An advance item moves the named point
// by one Euler step; a load item overwrites its coordinates. Either one returns exactly one
// transaction on the result channel with the new coordinates, the pixel column and row
// and the on-screen flag. An index past the point store returns zeros and changes nothing.
// The cfg channel writes one register per transaction and is always ready; write it only
// while no item is in flight.
// One item is handled at a time; the next item is accepted only once the last result
// has been issued. An advance item runs the advance schedule, a load item the load
// schedule, and an out-of-range index skips both. The pace is set by the single shared
// 33x33 multiplier, which runs eight products in sequence per advance and two per load.
// Reset clears the points to zero and loads the default register values. If the receiver
// stalls, the finished result waits in the output register and the next item is accepted
// and worked on; that item then holds until the output register is free.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module rossler_euler_step_to_pixel (
	input  logic               clk,
	input  logic               arst_n,
	rossler_item_if.sink       item,
	rossler_result_if.source   result,
	rossler_cfg_if.sink        cfg
);

	rossler_pkg::cmd_t cmd;
	rossler_pkg::sts_t sts;

	// Configuration writes complete at once.
	assign cfg.ready = 1'b1;

	// Controller.
	rossler_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.res_valid  (result.valid),
		.res_ready  (result.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	// Datapath.
	rossler_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.item_action      (item.action),
		.item_point_index (item.point_index),
		.item_load_x      (item.load_x),
		.item_load_y      (item.load_y),
		.item_load_z      (item.load_z),
		.cfg_we           (cfg.valid && cfg.ready),
		.cfg_index        (cfg.index),
		.cfg_data         (cfg.data),
		.out_index        (result.out_index),
		.pos_x            (result.pos_x),
		.pos_y            (result.pos_y),
		.pos_z            (result.pos_z),
		.pixel_col        (result.pixel_col),
		.pixel_row        (result.pixel_row),
		.on_screen        (result.on_screen)
	);

	// Only one item is in flight: an accepted item closes the input for the next cycle.
	`ASSERT_NEXT(a_one_in_flight, item.valid && item.ready, !item.ready, "second item accepted while busy")
	// A result is never loaded over one that is still waiting.
	`ASSERT_IMPLIES(a_no_overwrite, cmd.emit, !result.valid || result.ready, "result overwritten before transaction")
	// Products are written back only while an item is being worked on.
	`ASSERT_ALWAYS(a_wb_busy, cmd.wb_sel == rossler_pkg::WB_NONE || !item.ready, "writeback while idle")

endmodule
